>>> rtl/drt_pkg.sv
package drt_pkg;

  // Defaults and fixed limits
  localparam int MAX_RECTS_DEF = 8;
  localparam int BUFFER_LIMIT  = 65536;

  // Operation codes
  localparam logic [1:0] OP_MARK  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Configuration register indexes
  localparam logic REG_ROW_STRIDE   = 1'b0;
  localparam logic REG_BUFFER_BYTES = 1'b1;

  // Divider steps: one quotient bit per cycle over the 16-bit offset
  localparam int DIV_STEPS = 16;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] top;
    logic [16:0] right;
    logic [16:0] bottom;
  } rect_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_PIECE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_MERGE_WR,
    ST_APPEND,
    ST_FOLD_RD,
    ST_FOLD_ACC,
    ST_FOLD_WR,
    ST_READ_RD,
    ST_READ_DATA,
    ST_FINISH
  } drt_state_t;

endpackage

>>> rtl/dirty_rect_tracker_unit.sv
// A clear, an unused code or an out-of-range read goes straight to the result; a valid
// read first reads the rectangle memory; a mark divides the offset by the row stride, then
// scans the stored list for each row piece and folds the full list into one rectangle.
// Marks use the 16-step serial divider and the one-port rectangle memory scan.
// One transaction at a time; the next is taken in the cycle after the result is loaded,
// and a result is loaded only when the previous one is not held by out_stall.
// rst (synchronous) empties the list and sets row_stride 0, buffer_bytes 65536.
module dirty_rect_tracker_unit
  import drt_pkg::*;
#(
  parameter int MAX_RECTS = MAX_RECTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [15:0] byte_offset,
  input  logic [2:0]  span_length,
  input  logic [3:0]  rect_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  rect_count,
  output logic [15:0] left_col,
  output logic [15:0] top_row,
  output logic [16:0] right_col,
  output logic [16:0] bottom_row
);

  localparam int AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int CW = $clog2(MAX_RECTS + 1);
  localparam int DCW = $clog2(DIV_STEPS + 1);

  // Bounding box of two rectangles
  function automatic rect_t grow(rect_t a, rect_t b);
    rect_t g;
    g.left   = (b.left < a.left) ? b.left : a.left;
    g.top    = (b.top < a.top) ? b.top : a.top;
    g.right  = (b.right > a.right) ? b.right : a.right;
    g.bottom = (b.bottom > a.bottom) ? b.bottom : a.bottom;
    return g;
  endfunction

  drt_state_t state, state_next;

  logic [15:0]   row_stride;
  logic [16:0]   buffer_bytes;
  logic [CW-1:0] count;
  logic          out_load;

  logic [1:0]    op_q;
  logic [3:0]    idx_q;
  logic [2:0]    len_left;
  logic [16:0]   stride;
  logic [15:0]   dividend;
  logic [16:0]   rem;
  logic [15:0]   quot;
  logic [DCW-1:0] div_cnt;
  logic [15:0]   cur_col;
  logic [15:0]   cur_row;
  rect_t         piece;
  rect_t         acc;
  rect_t         res;
  logic [AW-1:0] scan_k;

  // Rectangle store
  rect_t         mem [MAX_RECTS];
  rect_t         rd_data;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  rect_t         mem_wdata;

  // Accept-time decode
  logic [16:0] size;
  logic [24:0] bb_wide;
  logic [16:0] room;
  logic [2:0]  len_clip;
  logic [2:0]  len_eff;
  logic        mark_ok;
  logic        read_ok;
  logic        in_accept;

  // Scan decode
  logic        hit;
  logic        scan_last;
  logic        list_full;
  logic [16:0] piece_room;
  logic [2:0]  take;
  logic [17:0] trial;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  // Clip window size and span length
  always_comb begin
    bb_wide  = 25'(buffer_bytes);
    if (buffer_bytes == 17'd0) begin
      size = 17'd1;
    end else if (bb_wide > 25'(BUFFER_LIMIT)) begin
      size = 17'(BUFFER_LIMIT);
    end else begin
      size = buffer_bytes;
    end
    room     = size - 17'(byte_offset);
    len_clip = (span_length > 3'd4) ? 3'd4 : span_length;
    len_eff  = (17'(len_clip) > room) ? room[2:0] : len_clip;
    mark_ok  = (17'(byte_offset) < size) && (span_length != 3'd0);
    read_ok  = (8'(rect_index) < 8'(count));
  end

  always_comb begin
    hit = (rd_data.left < piece.right[15:0] || piece.right[16]) &&
          (rd_data.right > 17'(piece.left)) &&
          (rd_data.top < piece.bottom[15:0] || piece.bottom[16]) &&
          (rd_data.bottom > 17'(piece.top));
    scan_last  = (8'(scan_k) + 8'd1 >= 8'(count));
    list_full  = (8'(count) >= 8'(MAX_RECTS));
    piece_room = stride - 17'(cur_col);
    take       = (piece_room < 17'(len_left)) ? piece_room[2:0] : len_left;
    trial      = {rem, dividend[15]};
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          if (operation == OP_MARK && mark_ok) begin
            state_next = ST_DIV;
          end else if (operation == OP_READ && read_ok) begin
            state_next = ST_READ_RD;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_DIV: begin
        if (div_cnt == DCW'(DIV_STEPS - 1)) state_next = ST_PIECE;
      end
      ST_PIECE: begin
        state_next = (count == '0) ? ST_APPEND : ST_SCAN_RD;
      end
      ST_SCAN_RD: state_next = ST_SCAN_CMP;
      ST_SCAN_CMP: begin
        if (hit) begin
          state_next = ST_MERGE_WR;
        end else if (!scan_last) begin
          state_next = ST_SCAN_RD;
        end else if (!list_full) begin
          state_next = ST_APPEND;
        end else begin
          state_next = ST_FOLD_RD;
        end
      end
      ST_MERGE_WR, ST_APPEND, ST_FOLD_WR: begin
        state_next = (len_left != 3'd0) ? ST_PIECE : ST_FINISH;
      end
      ST_FOLD_RD: state_next = ST_FOLD_ACC;
      ST_FOLD_ACC: begin
        state_next = (scan_k == AW'(MAX_RECTS - 1)) ? ST_FOLD_WR : ST_FOLD_RD;
      end
      ST_READ_RD: state_next = ST_READ_DATA;
      ST_READ_DATA: state_next = ST_FINISH;
      ST_FINISH: begin
        if (!out_valid || !out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory control and result load
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = scan_k;
    mem_wdata = acc;
    out_load  = 1'b0;
    unique case (state)
      ST_MERGE_WR: mem_we = 1'b1;
      ST_APPEND: begin
        mem_we    = 1'b1;
        mem_addr  = AW'(count);
        mem_wdata = piece;
      end
      ST_FOLD_WR: begin
        mem_we   = 1'b1;
        mem_addr = '0;
      end
      ST_READ_RD: mem_addr = AW'(idx_q);
      ST_FINISH: out_load = !out_valid || !out_stall;
      default: ;
    endcase
  end

  // Store: one port, one address per cycle, read data registered
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rd_data <= mem[mem_addr];
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      out_valid    <= 1'b0;
      row_stride   <= 16'd0;
      buffer_bytes <= 17'd65536;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        if (cfg_index == REG_ROW_STRIDE) row_stride <= cfg_data[15:0];
        if (cfg_index == REG_BUFFER_BYTES) buffer_bytes <= cfg_data;
      end
      if (in_accept && operation == OP_CLEAR) count <= '0;
      if (state == ST_APPEND) count <= count + CW'(1);
      if (state == ST_FOLD_WR) count <= CW'(1);
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        op_q     <= operation;
        idx_q    <= rect_index;
        len_left <= len_eff;
        stride   <= (row_stride == 16'd0) ? size : 17'(row_stride);
        dividend <= byte_offset;
        rem      <= 17'd0;
        div_cnt  <= '0;
        res      <= '0;
      end
      ST_DIV: begin
        // Restoring division: one quotient bit per cycle
        if (trial >= 18'(stride)) begin
          rem  <= 17'(trial - 18'(stride));
          quot <= {quot[14:0], 1'b1};
        end else begin
          rem  <= trial[16:0];
          quot <= {quot[14:0], 1'b0};
        end
        dividend <= {dividend[14:0], 1'b0};
        div_cnt  <= div_cnt + DCW'(1);
        cur_col  <= 16'(trial >= 18'(stride) ? trial - 18'(stride) : trial);
        cur_row  <= {quot[14:0], (trial >= 18'(stride))};
      end
      ST_PIECE: begin
        // Cut one row piece; any rest starts at column zero of the next row
        piece.left   <= cur_col;
        piece.top    <= cur_row;
        piece.right  <= 17'(cur_col) + 17'(take);
        piece.bottom <= 17'(cur_row) + 17'd1;
        len_left     <= len_left - take;
        cur_col      <= 16'd0;
        cur_row      <= cur_row + 16'd1;
        scan_k       <= '0;
      end
      ST_SCAN_CMP: begin
        if (hit) begin
          acc <= grow(rd_data, piece);
        end else if (!scan_last) begin
          scan_k <= scan_k + AW'(1);
        end else begin
          acc    <= piece;
          scan_k <= '0;
        end
      end
      ST_FOLD_ACC: begin
        acc    <= grow(acc, rd_data);
        scan_k <= scan_k + AW'(1);
      end
      ST_READ_DATA: begin
        if (op_q == OP_READ) res <= rd_data;
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      rect_count <= 4'(count);
      left_col   <= res.left;
      top_row    <= res.top;
      right_col  <= res.right;
      bottom_row <= res.bottom;
    end
  end

endmodule

>>> rtl/drt_checker.sv
module drt_checker
  import drt_pkg::*;
#(
  parameter int MAX_RECTS = MAX_RECTS_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  rect_count,
  input logic [15:0] left_col,
  input logic [15:0] top_row,
  input logic [16:0] right_col,
  input logic [16:0] bottom_row
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(rect_count))
    else $error("stalled result dropped or changed");

  // Never report more rectangles than the list holds
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && (MAX_RECTS < 16) |-> int'(rect_count) <= MAX_RECTS)
    else $error("rectangle count above list size");

  // A returned rectangle has positive width
  a_width: assert property (@(posedge clk) disable iff (rst)
    out_valid && right_col != 17'd0 |-> 17'(left_col) < right_col)
    else $error("rectangle with empty column range");

  // A returned rectangle has positive height
  a_height: assert property (@(posedge clk) disable iff (rst)
    out_valid && bottom_row != 17'd0 |-> 17'(top_row) < bottom_row)
    else $error("rectangle with empty row range");

endmodule

bind dirty_rect_tracker_unit drt_checker #(.MAX_RECTS(MAX_RECTS)) u_drt_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .rect_count (rect_count),
  .left_col   (left_col),
  .top_row    (top_row),
  .right_col  (right_col),
  .bottom_row (bottom_row)
);

>>> bench/tb.sv
module tb;
  import drt_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic        cfg_index;
  logic [16:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  operation;
  logic [15:0] byte_offset;
  logic [2:0]  span_length;
  logic [3:0]  rect_index;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  rect_count;
  logic [15:0] left_col;
  logic [15:0] top_row;
  logic [16:0] right_col;
  logic [16:0] bottom_row;

  typedef struct packed {
    logic [3:0]  cnt;
    logic [15:0] l;
    logic [15:0] t;
    logic [16:0] r;
    logic [16:0] b;
  } rect_reply_t;

  // Shadow copy of the rectangle list and registers
  rect_t       shadow_rects [MAX_RECTS_DEF];
  int unsigned shadow_count;
  int unsigned shadow_stride;
  int unsigned shadow_bytes;

  rect_reply_t pending_replies[$];
  int          error_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          quiet_cycles;

  localparam int WATCHDOG_LIMIT = 20000;

  dirty_rect_tracker_unit dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .byte_offset(byte_offset),
    .span_length(span_length), .rect_index(rect_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .rect_count(rect_count), .left_col(left_col), .top_row(top_row),
    .right_col(right_col), .bottom_row(bottom_row)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Widen rectangle k to cover the given box
  function automatic void widen_rect(int k, int unsigned l, int unsigned t,
                                     int unsigned r, int unsigned b);
    if (l < shadow_rects[k].left) shadow_rects[k].left = 16'(l);
    if (t < shadow_rects[k].top) shadow_rects[k].top = 16'(t);
    if (r > shadow_rects[k].right) shadow_rects[k].right = 17'(r);
    if (b > shadow_rects[k].bottom) shadow_rects[k].bottom = 17'(b);
  endfunction

  // Merge into first overlap, else append, else fold the whole list
  function automatic void place_piece(int unsigned l, int unsigned t,
                                      int unsigned r, int unsigned b);
    for (int k = 0; k < shadow_count; k++) begin
      if (shadow_rects[k].left < r && shadow_rects[k].right > l &&
          shadow_rects[k].top < b && shadow_rects[k].bottom > t) begin
        widen_rect(k, l, t, r, b);
        return;
      end
    end
    if (shadow_count < MAX_RECTS_DEF) begin
      shadow_rects[shadow_count] = '{left: 16'(l), top: 16'(t), right: 17'(r),
                                     bottom: 17'(b)};
      shadow_count++;
      return;
    end
    for (int k = 1; k < MAX_RECTS_DEF; k++)
      widen_rect(0, shadow_rects[k].left, shadow_rects[k].top,
                 shadow_rects[k].right, shadow_rects[k].bottom);
    widen_rect(0, l, t, r, b);
    shadow_count = 1;
  endfunction

  function automatic void mark_bytes(int unsigned offs, int unsigned len);
    int unsigned size;
    int unsigned stride;
    int unsigned row;
    int unsigned col;
    int unsigned take;
    size = shadow_bytes;
    if (size == 0) size = 1;
    if (size > BUFFER_LIMIT) size = BUFFER_LIMIT;
    if (offs >= size) return;
    if (len > 4) len = 4;
    if (len > size - offs) len = size - offs;
    stride = (shadow_stride != 0) ? shadow_stride : size;
    while (len > 0) begin
      row = offs / stride;
      col = offs % stride;
      take = stride - col;
      if (take > len) take = len;
      place_piece(col & 16'hFFFF, row & 16'hFFFF, (col + take) & 17'h1FFFF,
                  (row + 1) & 17'h1FFFF);
      offs += take;
      len -= take;
    end
  endfunction

  function automatic rect_reply_t apply_item(logic [1:0] op, logic [15:0] offs,
                                             logic [2:0] len, logic [3:0] idx);
    rect_reply_t rep;
    rep = '0;
    if (op == OP_MARK) mark_bytes(offs, len);
    else if (op == OP_CLEAR) shadow_count = 0;
    else if (op == OP_READ && idx < shadow_count) begin
      rep.l = shadow_rects[idx].left;
      rep.t = shadow_rects[idx].top;
      rep.r = shadow_rects[idx].right;
      rep.b = shadow_rects[idx].bottom;
    end
    rep.cnt = 4'(shadow_count);
    return rep;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Send one transaction and queue its expected reply
  task automatic send_item(logic [1:0] op, logic [15:0] offs, logic [2:0] len,
                           logic [3:0] idx);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid <= 1'b1;
    operation <= op;
    byte_offset <= offs;
    span_length <= len;
    rect_index <= idx;
    do @(posedge clk); while (in_stall);
    pending_replies.push_back(apply_item(op, offs, len, idx));
    @(negedge clk);
    in_valid <= 1'b0;
    // The block stalls for at least this cycle after an accept
    @(negedge clk);
  endtask

  // Wait until every queued reply has arrived, so the block is idle
  task automatic drain;
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, int unsigned val);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 17'(val);
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_ROW_STRIDE) shadow_stride = val & 16'hFFFF;
    else shadow_bytes = val & 17'h1FFFF;
  endtask

  // Mark offsets mostly inside the window, read back, clear now and then, send unused codes
  task automatic send_random(int n, int unsigned window);
    int unsigned pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 60)
        send_item(OP_MARK, (pick < 3) ? 16'($urandom) : 16'($urandom_range(window - 1)),
                  3'($urandom), 4'($urandom_range(MAX_RECTS_DEF - 1)));
      else if (pick < 90)
        send_item(OP_READ, 16'($urandom), 3'($urandom), 4'($urandom_range(15)));
      else if (pick < 95)
        send_item(OP_CLEAR, 16'($urandom), 3'($urandom), 4'($urandom));
      else
        send_item(2'd3, 16'($urandom), 3'($urandom), 4'($urandom));
    end
  endtask

  // Read back every slot of the list and one past its end
  task automatic read_all;
    for (int k = 0; k <= MAX_RECTS_DEF; k++) send_item(OP_READ, '0, '0, 4'(k));
  endtask

  task automatic test_directed;
    send_item(OP_READ, 16'h0, 3'd1, 4'd0);
    send_item(OP_MARK, 16'h0, 3'd1, 4'd0);
    send_item(OP_MARK, 16'hFFFF, 3'd4, 4'd15);
    send_item(OP_MARK, 16'h0001, 3'd0, 4'd0);
    send_item(OP_MARK, 16'h0002, 3'd7, 4'd0);
    send_item(2'd3, 16'hFFFF, 3'd7, 4'd15);
    read_all();
    send_item(OP_READ, '0, '0, 4'd15);
    send_item(OP_CLEAR, 16'hFFFF, 3'd7, 4'd15);
    write_reg(REG_ROW_STRIDE, 16);
    write_reg(REG_BUFFER_BYTES, 100);
    send_item(OP_MARK, 16'd14, 3'd4, '0);
    send_item(OP_MARK, 16'd98, 3'd4, '0);
    send_item(OP_MARK, 16'd100, 3'd1, '0);
    for (int k = 0; k < 9; k++) send_item(OP_MARK, 16'(k * 40), 3'd1, '0);
    read_all();
  endtask

  task automatic test_settings;
    int unsigned strides [5] = '{0, 1, 7, 64, 65535};
    int unsigned sizes [5] = '{0, 1, 300, 65536, 131071};
    for (int p = 0; p < 5; p++) begin
      write_reg(REG_ROW_STRIDE, strides[p]);
      write_reg(REG_BUFFER_BYTES, sizes[(p + 2) % 5]);
      send_item(OP_CLEAR, '0, '0, '0);
      send_random(200, (sizes[(p + 2) % 5] == 0) ? 1 :
                  (sizes[(p + 2) % 5] > 65536) ? 65536 : sizes[(p + 2) % 5]);
    end
  endtask

  task automatic test_small_grid;
    write_reg(REG_ROW_STRIDE, $urandom_range(2, 12));
    write_reg(REG_BUFFER_BYTES, 64);
    send_random(200, 64);
    drain();
    send_random(200, 64);
  endtask

  task automatic test_wide_rows;
    write_reg(REG_ROW_STRIDE, 0);
    write_reg(REG_BUFFER_BYTES, 65536);
    send_random(350, 65536);
  endtask

  // Compare each reply with the oldest expectation
  always @(posedge clk) begin
    rect_reply_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected reply", 1, 0);
      end else begin
        want = pending_replies.pop_front();
        if (rect_count !== want.cnt) report_mismatch("rect_count", rect_count, want.cnt);
        if (left_col !== want.l) report_mismatch("left_col", left_col, want.l);
        if (top_row !== want.t) report_mismatch("top_row", top_row, want.t);
        if (right_col !== want.r) report_mismatch("right_col", right_col, want.r);
        if (bottom_row !== want.b) report_mismatch("bottom_row", bottom_row, want.b);
      end
    end
  end

  // Stall the reply side at random
  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  // Stop on a long stretch with no transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    operation = '0;
    byte_offset = '0;
    span_length = '0;
    rect_index = '0;
    out_stall = 1'b0;
    error_count = 0;
    quiet_cycles = 0;
    shadow_count = 0;
    shadow_stride = 0;
    shadow_bytes = 65536;
    foreach (shadow_rects[k]) shadow_rects[k] = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    send_idle_pct = 30;
    recv_idle_pct = 73;
    test_directed();
    test_settings();
    send_idle_pct = 73;
    recv_idle_pct = 30;
    test_small_grid();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_wide_rows();

    drain();
    if (error_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> sim.f
rtl/drt_pkg.sv
rtl/dirty_rect_tracker_unit.sv
rtl/drt_checker.sv
bench/tb.sv
